[sv/gr_pkg.sv]
`default_nettype none
package gr_pkg;

    localparam int OP_W     = 2;
    localparam int CELL_W   = 6;
    localparam int ANGLE_W  = 16;
    localparam int POS_W    = 22;
    localparam int DIST_W   = 24;
    localparam int END_W    = 24;
    localparam int STEP_W   = 8;
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;

    localparam int MAP_COLUMNS = 64;
    localparam int MAP_ROWS    = 64;
    localparam int MAP_DEPTH   = MAP_COLUMNS * MAP_ROWS;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);
    localparam int COL_W       = $clog2(MAP_COLUMNS);
    localparam int ROW_W       = $clog2(MAP_ROWS);

    localparam int CORDIC_ITERS = 20;
    localparam int DIV_BITS     = 23;
    localparam int SQRT_ITERS   = 25;

    localparam logic [OP_W-1:0]   OP_WRITE        = 2'd0;
    localparam logic [OP_W-1:0]   OP_CAST_X       = 2'd1;
    localparam logic [OP_W-1:0]   OP_CAST_Y       = 2'd2;
    localparam logic [STEP_W-1:0] MAX_STEPS_RESET = 8'd64;
    localparam logic [22:0]       RATIO_SAT       = 23'h7FFFFF;
    localparam logic [PADDR_W-1:0] ADDR_MAX_STEPS = 2'd0;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_WRITE,
        JOB_CAST_X,
        JOB_CAST_Y
    } t_job_kind;

    typedef struct packed {
        t_job_kind                kind;
        logic                     wr_en;
        logic [MAP_AW-1:0]        addr;
        logic                     blocks;
        logic [ANGLE_W-1:0]       angle;
        logic [POS_W-1:0]         px;
        logic [POS_W-1:0]         py;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    // Rotation angles, 2^24 units per turn.
    function automatic logic [21:0] arc_at(input logic [4:0] idx);
        logic [21:0] a;
        case (idx)
            5'd0:  a = 22'd2097152;
            5'd1:  a = 22'd1238021;
            5'd2:  a = 22'd654136;
            5'd3:  a = 22'd332050;
            5'd4:  a = 22'd166669;
            5'd5:  a = 22'd83416;
            5'd6:  a = 22'd41718;
            5'd7:  a = 22'd20860;
            5'd8:  a = 22'd10430;
            5'd9:  a = 22'd5215;
            5'd10: a = 22'd2608;
            5'd11: a = 22'd1304;
            5'd12: a = 22'd652;
            5'd13: a = 22'd326;
            5'd14: a = 22'd163;
            5'd15: a = 22'd81;
            5'd16: a = 22'd41;
            5'd17: a = 22'd20;
            5'd18: a = 22'd10;
            5'd19: a = 22'd5;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[sv/gr_in_if.sv]
`default_nettype none
interface gr_in_if;
    logic                        valid;
    logic                        ready;
    logic [gr_pkg::OP_W-1:0]     operation;
    logic [gr_pkg::CELL_W-1:0]   cell_x;
    logic [gr_pkg::CELL_W-1:0]   cell_y;
    logic                        cell_blocks;
    logic [gr_pkg::ANGLE_W-1:0]  angle;
    logic [gr_pkg::POS_W-1:0]    player_x;
    logic [gr_pkg::POS_W-1:0]    player_y;

    modport source (output valid, operation, cell_x, cell_y, cell_blocks, angle,
                    player_x, player_y, input ready);
    modport sink   (input valid, operation, cell_x, cell_y, cell_blocks, angle,
                    player_x, player_y, output ready);
endinterface
`default_nettype wire

[sv/gr_out_if.sv]
`default_nettype none
interface gr_out_if;
    logic                       valid;
    logic                       ready;
    logic [gr_pkg::DIST_W-1:0]  distance;
    logic signed [gr_pkg::END_W-1:0] end_x;
    logic signed [gr_pkg::END_W-1:0] end_y;
    logic                       wall_found;

    modport source (output valid, distance, end_x, end_y, wall_found, input ready);
    modport sink   (input valid, distance, end_x, end_y, wall_found, output ready);
endinterface
`default_nettype wire

[sv/grid_ray_wall_distance.sv]
`default_nettype none
// Grid ray caster over a 64 x 64 wall-bit map. After reset the map is cleared
// by a pass over all 4096 cells, one cell a cycle, during which no word is
// accepted (the max_steps register can still be written). A front end takes
// words into a two-entry queue; the back end runs them one at a time. A cast
// visits at most max_steps grid lines and runs 20 CORDIC rotations, two
// bit-serial dividers side by side for tan and cot with 23-bit quotients, one
// multiply, a probe and a check state per grid line on the single map port,
// two squaring steps and 25 steps of bit-serial square root. A finished
// result waits in the output register while the queue keeps taking new words
// until it is full.
module grid_ray_wall_distance (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [gr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [gr_pkg::PDATA_W-1:0] pwdata,
    output logic      [gr_pkg::PDATA_W-1:0] prdata,
    output logic                            pready,
    gr_in_if.sink                           i_ray,
    gr_out_if.source                        o_res
);
    import gr_pkg::*;

    logic [STEP_W-1:0] r_max_steps;
    t_head             head;
    t_back_ctl         ctl;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MAX_STEPS);
    assign prdata = (paddr == ADDR_MAX_STEPS) ? PDATA_W'(r_max_steps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps <= MAX_STEPS_RESET;
        end else if (cfg_wr) begin
            r_max_steps <= pwdata[STEP_W-1:0];
        end
    end

    gr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (i_ray),
        .i_ctl   (ctl),
        .o_head  (head)
    );

    gr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_steps (r_max_steps),
        .i_head      (head),
        .o_ctl       (ctl),
        .o_res       (o_res)
    );

    // No word enters while the map is being cleared.
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clearing |-> !i_ray.ready)
        else $error("input accepted during map clear");

    // The back end only takes a word the queue holds.
    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |-> head.valid)
        else $error("queue popped while empty");

    a_cfg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_max_steps == $past(pwdata[STEP_W-1:0])))
        else $error("max_steps write lost");
endmodule
`default_nettype wire

[sv/gr_ram.sv]
`default_nettype none
module gr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[sv/gr_front.sv]
`default_nettype none
module gr_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gr_in_if.sink                  i_ray,
    input  wire gr_pkg::t_back_ctl i_ctl,
    output gr_pkg::t_head          o_head
);
    import gr_pkg::*;

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       job_in;
    logic       push;
    logic       pop;

    assign i_ray.ready = (r_cnt != 2'd2) && !i_ctl.clearing;
    assign push = i_ray.valid && i_ray.ready;
    assign pop  = i_ctl.pop && (r_cnt != 2'd0);

    always_comb begin
        job_in.wr_en  = (int'(i_ray.cell_x) < MAP_COLUMNS) && (int'(i_ray.cell_y) < MAP_ROWS);
        job_in.addr   = MAP_AW'(i_ray.cell_y) * MAP_AW'(MAP_COLUMNS) + MAP_AW'(i_ray.cell_x);
        job_in.blocks = i_ray.cell_blocks;
        job_in.angle  = i_ray.angle;
        job_in.px     = i_ray.player_x;
        job_in.py     = i_ray.player_y;
        case (i_ray.operation)
            OP_WRITE:  job_in.kind = JOB_WRITE;
            OP_CAST_X: job_in.kind = JOB_CAST_X;
            OP_CAST_Y: job_in.kind = JOB_CAST_Y;
            default:   job_in.kind = JOB_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= job_in;
                r_wp      <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_q[r_rp];
endmodule
`default_nettype wire

[sv/gr_back.sv]
`default_nettype none
module gr_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [gr_pkg::STEP_W-1:0] i_max_steps,
    input  wire gr_pkg::t_head             i_head,
    output gr_pkg::t_back_ctl              o_ctl,
    gr_out_if.source                       o_res
);
    import gr_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CORDIC, S_DIVSET, S_DIV, S_MUL, S_INIT,
        S_PROBE, S_CHECK, S_SQX, S_SQY, S_SQRT, S_DONE
    } t_state;

    t_state               r_state;
    logic [MAP_AW-1:0]    r_clr;
    t_job_kind            r_kind;
    logic [POS_W-1:0]     r_px;
    logic [POS_W-1:0]     r_py;
    logic                 r_neg;
    logic                 r_negx;
    logic                 r_negy;
    logic signed [32:0]   r_x;
    logic signed [32:0]   r_y;
    logic signed [24:0]   r_z;
    logic [4:0]           r_i;
    logic [31:0]          r_ax;
    logic [31:0]          r_ay;
    logic [31:0]          r_tr;
    logic [31:0]          r_cr;
    logic [22:0]          r_tn;
    logic [22:0]          r_cn;
    logic [22:0]          r_tq;
    logic [22:0]          r_cq;
    logic                 r_tsat;
    logic                 r_csat;
    logic [39:0]          r_prod;
    logic                 r_psign;
    logic signed [33:0]   r_cx;
    logic signed [33:0]   r_cy;
    logic signed [33:0]   r_sx;
    logic signed [33:0]   r_sy;
    logic [STEP_W-1:0]    r_cnt;
    logic                 r_inmap;
    logic                 r_offedge;
    logic                 r_found;
    logic                 r_zero;
    logic                 r_big;
    logic [23:0]          r_dy;
    logic [49:0]          r_sq;
    logic [49:0]          r_rt;
    logic [49:0]          r_bit;
    logic                 r_oval;
    logic [DIST_W-1:0]    r_dist;
    logic [END_W-1:0]     r_ex;
    logic [END_W-1:0]     r_ey;
    logic                 r_wall;

    logic                 ram_we;
    logic [MAP_AW-1:0]    ram_addr;
    logic                 ram_wdata;
    logic                 ram_rdata;

    // CORDIC step values
    logic signed [32:0]   xs;
    logic signed [32:0]   ys;
    logic signed [24:0]   arc;
    // Divider step values
    logic [32:0]          trem;
    logic [32:0]          crem;
    logic                 tge;
    logic                 cge;
    logic [22:0]          tmag;
    logic [22:0]          cmag;
    // Probe address
    logic [17:0]          mxz;
    logic [17:0]          myz;
    logic                 inx;
    logic                 iny;
    logic                 subx;
    logic                 suby;
    logic [17:0]          colv;
    logic [17:0]          rowv;
    logic [MAP_AW-1:0]    probe_addr;
    // Start-up values
    logic [15:0]          q16;
    logic                 half_neg;
    logic [15:0]          frac;
    logic                 ng;
    logic [22:0]          ratio;
    logic [16:0]          dmag;
    logic signed [33:0]   pq;
    // Distance values
    logic signed [33:0]   dxs;
    logic signed [33:0]   dys;
    logic [33:0]          dxa;
    logic [33:0]          dya;
    logic [49:0]          rtb;
    logic                 out_load;
    logic                 is_x;

    gr_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign is_x = (r_kind == JOB_CAST_X);

    always_comb begin
        xs   = r_x >>> r_i;
        ys   = r_y >>> r_i;
        arc  = $signed({3'b000, arc_at(r_i)});
        trem = {r_tr, r_tn[22]};
        crem = {r_cr, r_cn[22]};
        tge  = trem >= {1'b0, r_ax};
        cge  = crem >= {1'b0, r_ay};
        tmag = r_tsat ? RATIO_SAT : r_tq;
        cmag = r_csat ? RATIO_SAT : r_cq;

        half_neg = i_head.job.angle[14:0] > 15'd16384;
        q16 = half_neg ? (16'd32768 - {1'b0, i_head.job.angle[14:0]})
                       : {1'b0, i_head.job.angle[14:0]};

        frac  = is_x ? r_px[15:0] : r_py[15:0];
        ng    = is_x ? r_negx : r_negy;
        ratio = is_x ? tmag : cmag;
        dmag  = ng ? {1'b0, frac} : (17'h10000 - {1'b0, frac});
        pq    = $signed({10'b0, r_prod[39:16]});

        // A coordinate just below zero still truncates to cell zero.
        mxz  = r_cx[33] ? 18'd0 : r_cx[33:16];
        myz  = r_cy[33] ? 18'd0 : r_cy[33:16];
        inx  = r_cx[33] ? (r_cx > -34'sd65536) : (mxz < 18'(MAP_COLUMNS));
        iny  = r_cy[33] ? (r_cy > -34'sd65536) : (myz < 18'(MAP_ROWS));
        subx = is_x && r_negx;
        suby = (r_kind == JOB_CAST_Y) && r_negy;
        colv = mxz - 18'(subx);
        rowv = myz - 18'(suby);
        probe_addr = MAP_AW'(rowv[ROW_W-1:0]) * MAP_AW'(MAP_COLUMNS)
                   + MAP_AW'(colv[COL_W-1:0]);

        dxs = r_cx - $signed({12'b0, r_px});
        dys = r_cy - $signed({12'b0, r_py});
        dxa = dxs[33] ? 34'(-dxs) : 34'(dxs);
        dya = dys[33] ? 34'(-dys) : 34'(dys);
        rtb = r_rt + r_bit;

        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = probe_addr;
        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
            end
            S_IDLE: begin
                ram_we    = i_head.valid && (i_head.job.kind == JOB_WRITE) && i_head.job.wr_en;
                ram_addr  = i_head.job.addr;
                ram_wdata = i_head.job.blocks;
            end
            default: begin
                ram_addr = probe_addr;
            end
        endcase
    end

    assign o_ctl.pop      = (r_state == S_IDLE) && i_head.valid;
    assign o_ctl.clearing = (r_state == S_CLEAR);
    assign out_load       = (r_state == S_DONE) && (!r_oval || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready && !out_load) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == MAP_AW'(MAP_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_kind  <= i_head.job.kind;
                        r_px    <= i_head.job.px;
                        r_py    <= i_head.job.py;
                        r_neg   <= half_neg;
                        r_negx  <= (i_head.job.angle >= 16'd16384) &&
                                   (i_head.job.angle <= 16'd49152);
                        r_negy  <= i_head.job.angle <= 16'd32768;
                        r_x     <= 33'sd1073741824;
                        r_y     <= '0;
                        r_z     <= $signed({1'b0, q16, 8'b0});
                        r_i     <= '0;
                        r_found <= 1'b0;
                        if ((i_head.job.kind == JOB_CAST_X) ||
                            (i_head.job.kind == JOB_CAST_Y)) begin
                            r_zero  <= 1'b0;
                            r_state <= S_CORDIC;
                        end else begin
                            r_zero  <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CORDIC: begin
                    if (!r_z[24]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - arc;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + arc;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(CORDIC_ITERS - 1)) begin
                        r_state <= S_DIVSET;
                    end
                end
                S_DIVSET: begin
                    logic [31:0] ax;
                    logic [31:0] ay;
                    ax = r_x[32] ? 32'(-r_x) : 32'(r_x);
                    ay = r_y[32] ? 32'(-r_y) : 32'(r_y);
                    r_ax   <= ax;
                    r_ay   <= ay;
                    // Quotient of 2^23 or more saturates; zero divisor falls in here too.
                    r_tsat <= {8'b0, ay} >= {1'b0, ax, 7'b0};
                    r_csat <= {8'b0, ax} >= {1'b0, ay, 7'b0};
                    r_tr   <= 32'(ay >> 7);
                    r_cr   <= 32'(ax >> 7);
                    r_tn   <= {ay[6:0], 16'b0};
                    r_cn   <= {ax[6:0], 16'b0};
                    r_i    <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_tr <= tge ? 32'(trem - {1'b0, r_ax}) : trem[31:0];
                    r_cr <= cge ? 32'(crem - {1'b0, r_ay}) : crem[31:0];
                    r_tn <= {r_tn[21:0], 1'b0};
                    r_cn <= {r_cn[21:0], 1'b0};
                    r_tq <= {r_tq[21:0], tge};
                    r_cq <= {r_cq[21:0], cge};
                    r_i  <= r_i + 5'd1;
                    if (r_i == 5'(DIV_BITS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 40'(dmag) * 40'(ratio);
                    r_psign <= (ng && (frac != 16'd0)) ^ r_neg;
                    if (is_x) begin
                        r_cx <= $signed({11'b0, {1'b0, r_px[21:16]} + 7'(!r_negx), 16'b0});
                        r_sx <= r_negx ? -34'sd65536 : 34'sd65536;
                        r_sy <= r_negy ? -$signed({11'b0, tmag}) : $signed({11'b0, tmag});
                    end else begin
                        r_cy <= $signed({11'b0, {1'b0, r_py[21:16]} + 7'(!r_negy), 16'b0});
                        r_sy <= r_negy ? -34'sd65536 : 34'sd65536;
                        r_sx <= r_negx ? -$signed({11'b0, cmag}) : $signed({11'b0, cmag});
                    end
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    if (is_x) begin
                        r_cy <= $signed({12'b0, r_py}) - (r_psign ? -pq : pq);
                    end else begin
                        r_cx <= $signed({12'b0, r_px}) - (r_psign ? -pq : pq);
                    end
                    r_cnt   <= '0;
                    r_state <= (i_max_steps == '0) ? S_SQX : S_PROBE;
                end
                S_PROBE: begin
                    r_inmap   <= inx && iny;
                    r_offedge <= (subx && (mxz == 18'd0)) || (suby && (myz == 18'd0));
                    r_state   <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_inmap && (r_offedge || ram_rdata)) begin
                        r_found <= 1'b1;
                        r_state <= S_SQX;
                    end else begin
                        r_cx  <= r_cx + r_sx;
                        r_cy  <= r_cy + r_sy;
                        r_cnt <= r_cnt + 1'b1;
                        r_state <= (r_cnt + 1'b1 == i_max_steps) ? S_SQX : S_PROBE;
                    end
                end
                S_SQX: begin
                    r_big   <= (dxa[33:24] != '0) || (dya[33:24] != '0);
                    r_sq    <= 50'(dxa[23:0] * dxa[23:0]);
                    r_dy    <= dya[23:0];
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sq    <= r_sq + 50'(r_dy * r_dy);
                    r_rt    <= '0;
                    r_bit   <= 50'(1) << 48;
                    r_i     <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sq >= rtb) begin
                        r_sq <= r_sq - rtb;
                        r_rt <= (r_rt >> 1) + r_bit;
                    end else begin
                        r_rt <= r_rt >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_i   <= r_i + 5'd1;
                    if (r_i == 5'(SQRT_ITERS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_oval <= 1'b1;
                        if (r_zero) begin
                            r_dist <= '0;
                            r_ex   <= '0;
                            r_ey   <= '0;
                            r_wall <= 1'b0;
                        end else begin
                            r_dist <= (r_big || (r_rt[49:24] != '0)) ? '1 : r_rt[23:0];
                            r_ex   <= (r_cx > 34'sd8388607) ? 24'h7FFFFF :
                                      (r_cx < -34'sd8388608) ? 24'h800000 : r_cx[23:0];
                            r_ey   <= (r_cy > 34'sd8388607) ? 24'h7FFFFF :
                                      (r_cy < -34'sd8388608) ? 24'h800000 : r_cy[23:0];
                            r_wall <= r_found;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid      = r_oval;
    assign o_res.distance   = r_dist;
    assign o_res.end_x      = $signed(r_ex);
    assign o_res.end_y      = $signed(r_ey);
    assign o_res.wall_found = r_wall;
endmodule
`default_nettype wire

[test/tb.sv]
`default_nettype none
module tb;
    import gr_pkg::*;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [CELL_W-1:0]  cx;
        logic [CELL_W-1:0]  cy;
        logic               blocks;
        logic [ANGLE_W-1:0] angle;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
    } t_ray_word;

    typedef struct {
        logic [DIST_W-1:0]       distance;
        logic signed [END_W-1:0] end_x;
        logic signed [END_W-1:0] end_y;
        logic                    wall_found;
    } t_hit;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam longint ONE_Q16 = 65536;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    gr_in_if  ray_if ();
    gr_out_if res_if ();

    grid_ray_wall_distance u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_ray   (ray_if),
        .o_res   (res_if)
    );

    // Shadow state of the block.
    bit          wall_bits [MAP_DEPTH];
    int unsigned step_limit = 64;
    longint      arc_steps [20] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    t_ray_word ray_words [$];
    t_hit      expected_hits [$];
    t_ray_word word_on_bus;
    int        gap_left;
    bit        calm;
    int        mismatches;
    int        hits_checked;
    int        walls_seen;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Magnitudes of tan and cot for a first-quadrant angle, Q7.16, saturating.
    function automatic void tan_cot(input int unsigned q, output longint tmag,
                                    output longint cmag);
        longint x, y, z, xs, ys, ax, ay, t, c;
        x = longint'(1) << 30;
        y = 0;
        z = longint'(q) << 8;
        for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - arc_steps[i];
            end else begin
                x = x + ys; y = y - xs; z = z + arc_steps[i];
            end
        end
        ax = mag(x);
        ay = mag(y);
        t = (ax == 0) ? RATIO_SAT : (ay << 16) / ax;
        c = (ay == 0) ? RATIO_SAT : (ax << 16) / ay;
        tmag = t > RATIO_SAT ? longint'(RATIO_SAT) : t;
        cmag = c > RATIO_SAT ? longint'(RATIO_SAT) : c;
    endfunction

    function automatic longint scale_q16(longint d, longint r);
        longint p;
        p = (mag(d) * mag(r)) >> 16;
        return ((d < 0) != (r < 0)) ? -p : p;
    endfunction

    function automatic longint grid_index(longint c);
        return c < 0 ? -((-c) >>> 16) : (c >>> 16);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [END_W-1:0] clamp24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[END_W-1:0];
    endfunction

    // Applies one word to the shadow map and returns the hit it should produce.
    function automatic t_hit trace_ray(t_ray_word w);
        t_hit   h;
        int unsigned half;
        bit     neg, negx, negy, blocked;
        longint tmag, cmag, tan_s, cot_s, px, py, cx, cy, sx, sy;
        longint mx, my, col, row, dx, dy;
        h = '{default: '0};
        if (w.op == OP_WRITE) begin
            wall_bits[{w.cy, w.cx}] = w.blocks;
            return h;
        end
        if (w.op == OP_UNUSED) return h;
        half = 32'(w.angle & 16'h7FFF);
        neg = half > 16384;
        tan_cot(neg ? 32768 - half : half, tmag, cmag);
        tan_s = neg ? -tmag : tmag;
        cot_s = neg ? -cmag : cmag;
        negx = w.angle >= 16384 && w.angle <= 49152;
        negy = w.angle <= 32768;
        px = w.px;
        py = w.py;
        if (w.op == OP_CAST_X) begin
            sx = negx ? -ONE_Q16 : ONE_Q16;
            sy = negy ? -tmag : tmag;
            cx = ((px >>> 16) + (negx ? 0 : 1)) * ONE_Q16;
            cy = py - scale_q16(cx - px, tan_s);
        end else begin
            sy = negy ? -ONE_Q16 : ONE_Q16;
            sx = negx ? -cmag : cmag;
            cy = ((py >>> 16) + (negy ? 0 : 1)) * ONE_Q16;
            cx = px - scale_q16(cy - py, cot_s);
        end
        for (int unsigned i = 0; i < step_limit; i++) begin
            mx = grid_index(cx);
            my = grid_index(cy);
            if (mx >= 0 && mx < MAP_COLUMNS && my >= 0 && my < MAP_ROWS) begin
                col = mx - ((w.op == OP_CAST_X && negx) ? 1 : 0);
                row = my - ((w.op == OP_CAST_Y && negy) ? 1 : 0);
                // A neighbor across the map edge counts as a wall.
                blocked = (col < 0 || row < 0) ? 1'b1
                        : wall_bits[row * MAP_COLUMNS + col];
                if (blocked) begin
                    h.wall_found = 1'b1;
                    break;
                end
            end
            cx = cx + sx;
            cy = cy + sy;
        end
        dx = mag(cx - px);
        dy = mag(cy - py);
        if (dx >= (longint'(1) << 24) || dy >= (longint'(1) << 24)) begin
            h.distance = '1;
        end else begin
            dx = root_floor(longint'(dx * dx + dy * dy));
            h.distance = dx > 24'hFFFFFF ? 24'hFFFFFF : dx[DIST_W-1:0];
        end
        h.end_x = clamp24(cx);
        h.end_y = clamp24(cy);
        return h;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender: presents words from the queue, predicting each one as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ray_if.valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (ray_if.valid && ray_if.ready)
                expected_hits.push_back(trace_ray(word_on_bus));
            if (!ray_if.valid || ray_if.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    ray_if.valid <= 1'b0;
                end else if (ray_words.size() > 0) begin
                    word_on_bus = ray_words.pop_front();
                    ray_if.operation   <= word_on_bus.op;
                    ray_if.cell_x      <= word_on_bus.cx;
                    ray_if.cell_y      <= word_on_bus.cy;
                    ray_if.cell_blocks <= word_on_bus.blocks;
                    ray_if.angle       <= word_on_bus.angle;
                    ray_if.player_x    <= word_on_bus.px;
                    ray_if.player_y    <= word_on_bus.py;
                    ray_if.valid <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    ray_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure and comparison against the oldest prediction.
    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: dist=%h x=%h y=%h wall=%b",
                                 res_if.distance, res_if.end_x, res_if.end_y,
                                 res_if.wall_found);
                end else begin
                    want = expected_hits.pop_front();
                    hits_checked++;
                    if (want.wall_found) walls_seen++;
                    if (res_if.distance !== want.distance || res_if.end_x !== want.end_x
                        || res_if.end_y !== want.end_y
                        || res_if.wall_found !== want.wall_found) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: got dist=%h x=%h y=%h wall=%b, want dist=%h x=%h y=%h wall=%b",
                                     hits_checked, res_if.distance, res_if.end_x,
                                     res_if.end_y, res_if.wall_found, want.distance,
                                     want.end_x, want.end_y, want.wall_found);
                    end
                end
            end
            res_if.ready <= calm ? 1'b1 : (pick_gap() == 0);
        end
    end

    task automatic add_write(int x, int y, bit b);
        t_ray_word w;
        w = '{op: OP_WRITE, cx: CELL_W'(x), cy: CELL_W'(y), blocks: b,
              angle: ANGLE_W'($urandom), px: POS_W'($urandom), py: POS_W'($urandom)};
        ray_words.push_back(w);
    endtask

    task automatic add_cast(logic [OP_W-1:0] op, int a, int x, int y);
        t_ray_word w;
        w = '{op: op, cx: CELL_W'($urandom), cy: CELL_W'($urandom),
              blocks: 1'($urandom), angle: ANGLE_W'(a), px: POS_W'(x), py: POS_W'(y)};
        ray_words.push_back(w);
    endtask

    task automatic add_random_word();
        int r, a;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            add_write($urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 9) < 4);
        end else if (r < 34) begin
            add_cast(OP_UNUSED, $urandom, $urandom, $urandom);
        end else begin
            a = $urandom;
            if ($urandom_range(0, 9) == 0)
                a = 16384 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
            add_cast(r < 67 ? OP_CAST_X : OP_CAST_Y, a & 16'hFFFF, $urandom,
                     $urandom);
        end
    endtask

    task automatic wait_drained();
        while (ray_words.size() != 0 || ray_if.valid || gap_left != 0
               || expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_max_steps(int unsigned v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_MAX_STEPS; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        step_limit = v & 8'hFF;
    endtask

    // Each phase sets the step limit on an idle block, then sends random words.
    task automatic run_phase(int unsigned steps, int count, bit quiet);
        wait_drained();
        set_max_steps(steps);
        calm = quiet;
        repeat (count) add_random_word();
        wait_drained();
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        ray_if.valid = 1'b0; ray_if.operation = '0; ray_if.cell_x = '0;
        ray_if.cell_y = '0; ray_if.cell_blocks = 1'b0; ray_if.angle = '0;
        ray_if.player_x = '0; ray_if.player_y = '0;
        res_if.ready = 1'b0;
        mismatches = 0; hits_checked = 0; walls_seen = 0; calm = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset step limit.
        add_write(0, 0, 1'b1);
        add_write(63, 63, 1'b1);
        add_write(10, 32, 1'b1);
        add_write(32, 10, 1'b1);
        add_write(63, 63, 1'b0);
        add_cast(OP_CAST_X, 0, 32 << 16, 32 << 16);
        add_cast(OP_CAST_Y, 16384, 32 << 16, 32 << 16);
        add_cast(OP_CAST_X, 32768, 32 << 16, 32 << 16);
        add_cast(OP_CAST_Y, 49152, 32 << 16, 32 << 16);
        add_cast(OP_CAST_X, 8192, 20 << 16, 40 << 16);
        add_cast(OP_CAST_Y, 24576, 40 << 16, 20 << 16);
        // Looking west or north from the first column or row hits the map edge.
        add_cast(OP_CAST_X, 32768, 100, 5 << 16);
        add_cast(OP_CAST_Y, 16384, 5 << 16, 100);
        add_cast(OP_CAST_X, 16'hFFFF, 22'h3FFFFF, 22'h3FFFFF);
        add_cast(OP_CAST_Y, 1, 0, 0);
        add_cast(OP_CAST_X, 16383, 22'h3FFFFF, 0);
        add_cast(OP_CAST_Y, 49153, 0, 22'h3FFFFF);
        add_cast(OP_UNUSED, 16'hFFFF, 22'h3FFFFF, 22'h3FFFFF);
        wait_drained();

        set_max_steps(0);
        add_cast(OP_CAST_X, 4000, 30 << 16, 30 << 16);
        add_cast(OP_CAST_Y, 40000, 30 << 16, 30 << 16);

        run_phase(64, 150, 1'b0);
        run_phase(1, 50, 1'b1);
        run_phase(255, 60, 1'b0);
        run_phase(0, 15, 1'b0);
        run_phase($urandom_range(2, 254), 100, 1'b0);
        run_phase($urandom_range(2, 254), 100, 1'b0);
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("checked %0d result words, %0d of them stopped by a wall,", hits_checked,
                 walls_seen);
        $display("over step limits 0, 1, 64, 255 and two random ones");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatching words", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
